// File: rtl/core/sost_pkg.sv
// ----------------------------------------------------------------------------
// sost_pkg
// Shared constants and types for the self-organizing search table.
// ----------------------------------------------------------------------------
package sost_pkg;

    // table geometry
    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int KEY_W = 32;
    localparam int POS_W = 5;

    // item opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // reorder policies (code 3 behaves as plain search)
    localparam logic [1:0] POL_PLAIN     = 2'd0;
    localparam logic [1:0] POL_TRANSPOSE = 2'd1;
    localparam logic [1:0] POL_HEAD      = 2'd2;

    // table memory access request
    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0] wr_data;
        logic [IDX_W-1:0] rd_addr;
    } mem_req_t;

endpackage

// File: rtl/core/sost_mem.sv
// ----------------------------------------------------------------------------
// sost_mem
// Table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sost_mem
    import sost_pkg::*;
(
    input  logic             clk,
    input  mem_req_t         req,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem_array [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_array[req.wr_addr] <= req.wr_data;
        end
    end

    // read port, registered read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem_array[req.rd_addr];
    end

endmodule

// File: rtl/core/self_organizing_search_table.sv
// ----------------------------------------------------------------------------
// self_organizing_search_table
// Key table with append, clear and search; search hits may reorder the table.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Append, clear, the
// unused opcode and a search of an empty table finish at once: the result
// strobe (done) rises the next cycle and busy never rises. A search reads one
// entry per cycle through the single read port of the table memory and
// compares it against the key in one shared comparator. The first compare
// comes in the cycle after the first read is issued. A search ends at the
// first hit or after the last entry is compared; a reordering hit then reads
// the partner entry and writes the two entries back through the single write
// port. done rises in the same cycle as busy falls. The longest search is a
// reordering hit on the last entry of a full table. Each item gives exactly
// one result beat on done, held for one cycle; the receiver cannot stall it.
// The policy register is written over cfg_valid/cfg_ready while idle.
// ----------------------------------------------------------------------------
module self_organizing_search_table
    import sost_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // command channel
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              opcode,
    input  logic signed [KEY_W-1:0] key,
    // result channel
    output logic                    done,
    output logic                    found,
    output logic [POS_W-1:0]        position,
    output logic                    full_error,
    // policy register write
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWAP_RD,
        ST_SWAP_WR_HIT,
        ST_SWAP_WR_PART
    } state_t;

    state_t           state_reg;
    logic [1:0]       policy_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             pend_reg;
    logic [KEY_W-1:0] key_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] part_idx_reg;
    logic             done_reg;
    logic             found_reg;
    logic [POS_W-1:0] position_reg;
    logic             full_error_reg;

    mem_req_t         mem_req;
    logic [KEY_W-1:0] mem_rd_data;

    logic             accept;
    logic             table_full;
    logic             hit;
    logic [IDX_W-1:0] cur_idx;
    logic             reorder;

    assign accept     = start && (state_reg == ST_IDLE);
    assign table_full = (count_reg == CNT_W'(DEPTH));
    assign busy       = (state_reg != ST_IDLE);
    assign cfg_ready  = (state_reg == ST_IDLE);

    // shared comparator; read data belongs to the entry before scan_idx
    assign cur_idx = IDX_W'(scan_idx_reg - CNT_W'(1));
    assign hit     = pend_reg && (mem_rd_data == key_reg);
    assign reorder = (cur_idx != '0)
                  && ((policy_reg == POL_TRANSPOSE) || (policy_reg == POL_HEAD));

    // memory request steering
    always_comb
    begin
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = count_reg[IDX_W-1:0];
        mem_req.wr_data = key;
        mem_req.rd_addr = scan_idx_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_req.wr_en = accept && (opcode == OP_APPEND) && !table_full;
            end
            ST_SCAN:
            begin
            end
            ST_SWAP_RD:
            begin
                mem_req.rd_addr = part_idx_reg;
            end
            ST_SWAP_WR_HIT:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = hit_idx_reg;
                mem_req.wr_data = mem_rd_data;
            end
            ST_SWAP_WR_PART:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = part_idx_reg;
                mem_req.wr_data = key_reg;
            end
            default:
            begin
            end
        endcase
    end

    sost_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // sequencer, table count, policy and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            policy_reg     <= POL_PLAIN;
            count_reg      <= '0;
            scan_idx_reg   <= '0;
            pend_reg       <= 1'b0;
            key_reg        <= '0;
            hit_idx_reg    <= '0;
            part_idx_reg   <= '0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            position_reg   <= '0;
            full_error_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= cfg_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg        <= key;
                        found_reg      <= 1'b0;
                        position_reg   <= '0;
                        full_error_reg <= 1'b0;
                        scan_idx_reg   <= '0;
                        pend_reg       <= 1'b0;
                        case (opcode)
                            OP_APPEND:
                            begin
                                done_reg <= 1'b1;
                                if (table_full)
                                begin
                                    full_error_reg <= 1'b1;
                                end
                                else
                                begin
                                    count_reg <= count_reg + CNT_W'(1);
                                end
                            end
                            OP_SEARCH:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_SCAN;
                                end
                            end
                            OP_CLEAR:
                            begin
                                done_reg  <= 1'b1;
                                count_reg <= '0;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        found_reg    <= 1'b1;
                        position_reg <= POS_W'(cur_idx);
                        hit_idx_reg  <= cur_idx;
                        part_idx_reg <= (policy_reg == POL_TRANSPOSE)
                                        ? (cur_idx - IDX_W'(1)) : '0;
                        if (reorder)
                        begin
                            state_reg <= ST_SWAP_RD;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (scan_idx_reg == count_reg)
                    begin
                        // last entry compared without a hit
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                        pend_reg     <= 1'b1;
                    end
                end
                ST_SWAP_RD:
                begin
                    state_reg <= ST_SWAP_WR_HIT;
                end
                ST_SWAP_WR_HIT:
                begin
                    state_reg <= ST_SWAP_WR_PART;
                end
                ST_SWAP_WR_PART:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign position   = position_reg;
    assign full_error = full_error_reg;

endmodule
